// File: hw/rtl/dsfs_pkg.sv
package dsfs_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_SERVERS     = 2;

    localparam int ID_W   = 16;
    localparam int TICK_W = 16;
    localparam int JOB_W  = ID_W + TICK_W;

    localparam logic KIND_ENQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PROC = 2'd1,
        ST_ENQ  = 2'd2,
        ST_DROP = 2'd3
    } t_status;

    typedef struct packed {
        logic              kind;
        logic              server;
        logic [ID_W-1:0]   client_id;
        logic [TICK_W-1:0] service_ticks;
    } t_in_word;

    typedef struct packed {
        logic            server_index;
        t_status         status;
        logic [ID_W-1:0] served_id;
        logic            last;
    } t_out_word;

    // queue bookkeeping request and flags for the selected server
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

// File: hw/rtl/dsfs_in_if.sv
interface dsfs_in_if;
    import dsfs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dsfs_out_if.sv
interface dsfs_out_if;
    import dsfs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/dsfs_ram.sv
module dsfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/dsfs_qctl.sv
module dsfs_qctl #(
    parameter int QUEUE_DEPTH = dsfs_pkg::DEF_QUEUE_DEPTH,
    parameter int SERVERS     = dsfs_pkg::DEF_SERVERS,
    localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1,
    localparam int PW = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SW-1:0]     i_sel,
    input  dsfs_pkg::t_q_cmd  i_cmd,
    output logic [PW-1:0]     o_head,
    output logic [PW-1:0]     o_tail,
    output dsfs_pkg::t_q_flags o_flags
);
    import dsfs_pkg::*;

    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int NQ = 1 << SW;

    logic [PW-1:0] r_head [NQ];
    logic [PW-1:0] r_tail [NQ];
    logic [OW-1:0] r_occ  [NQ];

    logic [OW-1:0] occ_sel;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign occ_sel       = r_occ[i_sel];
    assign o_head        = r_head[i_sel];
    assign o_tail        = r_tail[i_sel];
    assign o_flags.empty = (occ_sel == '0);
    assign o_flags.full  = (occ_sel == OW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_occ[q]  <= '0;
            end
        end else begin
            if (i_cmd.push) begin
                r_tail[i_sel] <= advance(r_tail[i_sel]);
                r_occ[i_sel]  <= occ_sel + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head[i_sel] <= advance(r_head[i_sel]);
                r_occ[i_sel]  <= occ_sel - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_flags.full)
        else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_flags.empty)
        else $error("pop from an empty queue");
    a_push_moves_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !i_cmd.pop) |=> (r_tail[$past(i_sel)] != $past(o_tail)))
        else $error("tail did not advance on push");
`endif
endmodule

// File: hw/rtl/dual_server_fifo_service_core.sv
// Dual server job queue core.
// Input channel i_in_ch carries one word per request: kind selects enqueue or
// tick, server picks the queue for an enqueue, client_id and service_ticks
// describe the job (zero ticks counts as one). Output channel o_out_ch
// returns result words: one per enqueue (enqueued or dropped), and one per
// server on a tick, server 0 first, with last set on the final word.
// An enqueue result passes through the S_ENQ state into the output register;
// a tick visits the servers in turn, server 0 first, each in an S_RD state
// that reads its head job from the single job memory and an S_WR state that
// writes any job back and loads its result word into the output register.
// A new request is taken only when the previous one is finished, while its
// last result may still wait in the output register.
// Reset (synchronous, active low) empties all queues at once; the job memory
// itself is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its word and the
// sequencer waits before producing the next result.
module dual_server_fifo_service_core #(
    parameter int QUEUE_DEPTH = dsfs_pkg::DEF_QUEUE_DEPTH,
    parameter int SERVERS     = dsfs_pkg::DEF_SERVERS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dsfs_in_if.sink           i_in_ch,
    dsfs_out_if.source        o_out_ch
);
    import dsfs_pkg::*;

    localparam int SW    = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int DEPTH = SERVERS << PW;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_ENQ, S_RD, S_WR} t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_k, n_k;
    logic              r_srv;
    logic [ID_W-1:0]   r_id;
    logic [TICK_W-1:0] r_ticks;
    logic              r_kind;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic              accept;
    logic              slot_free;
    logic              load;
    logic [SW-1:0]     sel;
    t_q_cmd            q_cmd;
    t_q_flags          q_flags;
    logic [PW-1:0]     q_head, q_tail;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [JOB_W-1:0]  mem_wdata, mem_rdata;
    logic [ID_W-1:0]   job_id;
    logic [TICK_W-1:0] job_rem, rem_dec;
    logic              srv_bad, drop, k_last;

    function automatic logic [AW-1:0] mk_addr(input logic [SW-1:0] s,
                                              input logic [PW-1:0] p);
        logic [SW+PW-1:0] full_addr;
        full_addr = {s, p};
        return full_addr[AW-1:0];
    endfunction

    dsfs_qctl #(.QUEUE_DEPTH(QUEUE_DEPTH), .SERVERS(SERVERS)) u_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (sel),
        .i_cmd   (q_cmd),
        .o_head  (q_head),
        .o_tail  (q_tail),
        .o_flags (q_flags)
    );

    dsfs_ram #(.WIDTH(JOB_W), .DEPTH(DEPTH)) u_jobs (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign accept         = i_in_ch.valid && i_in_ch.ready;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;
    assign slot_free      = !r_out_valid || o_out_ch.ready;

    assign sel       = (r_state == S_ENQ) ? SW'(r_srv) : r_k;
    assign mem_re    = (r_state == S_RD);
    assign mem_raddr = mk_addr(r_k, q_head);
    assign job_id    = mem_rdata[JOB_W-1:TICK_W];
    assign job_rem   = mem_rdata[TICK_W-1:0];
    assign rem_dec   = (job_rem == '0) ? '0 : job_rem - 1'b1;
    assign srv_bad   = (SERVERS == 1) && r_srv;
    assign drop      = srv_bad || q_flags.full;
    assign k_last    = (r_k == SW'(SERVERS - 1));

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        load        = 1'b0;
        q_cmd       = '0;
        mem_we      = 1'b0;
        mem_waddr   = mk_addr(sel, q_tail);
        mem_wdata   = {r_id, (r_ticks == '0) ? TICK_W'(1) : r_ticks};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k     = '0;
                    n_state = (i_in_ch.data.kind == KIND_ENQ) ? S_ENQ : S_RD;
                end
            end
            S_ENQ: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_out.server_index = r_srv;
                    n_out.status       = drop ? ST_DROP : ST_ENQ;
                    n_out.served_id    = r_id;
                    n_out.last         = 1'b1;
                    mem_we             = !drop;
                    q_cmd.push         = !drop;
                    n_state            = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_out.server_index = r_k[0];
                    n_out.last         = k_last;
                    if (q_flags.empty) begin
                        n_out.status    = ST_IDLE;
                        n_out.served_id = '0;
                    end else begin
                        n_out.status    = ST_PROC;
                        n_out.served_id = job_id;
                        mem_we          = 1'b1;
                        mem_waddr       = mk_addr(r_k, q_head);
                        mem_wdata       = {job_id, rem_dec};
                        q_cmd.pop       = (rem_dec == '0);
                    end
                    if (k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        if (accept) begin
            r_kind  <= i_in_ch.data.kind;
            r_srv   <= i_in_ch.data.server;
            r_id    <= i_in_ch.data.client_id;
            r_ticks <= i_in_ch.data.service_ticks;
        end
    end

`ifndef NO_ASSERTIONS
    a_mem_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("job memory read and write in the same cycle");
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out.last) |=> (r_state == S_IDLE))
        else $error("last word loaded but item still running");
    a_kind_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENQ) |-> (r_kind == KIND_ENQ))
        else $error("enqueue path taken for a tick");
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_ch.data.kind == KIND_TICK) |=> !load)
        else $error("tick result loaded in the cycle after accept");
`endif
endmodule

// File: test/tb_dual_server_fifo_service_core.sv
module tb_dual_server_fifo_service_core;
    import dsfs_pkg::*;

    localparam int NSRV             = DEF_SERVERS;
    localparam int QDEPTH           = DEF_QUEUE_DEPTH;
    localparam int RANDOM_PER_PHASE = 460;
    localparam int HOLD_CYCLES      = 500;
    localparam int TAIL_CYCLES      = 20;
    localparam int CYCLE_LIMIT      = 400000;

    typedef struct {
        t_in_word    word;
        int unsigned phase;
        bit          drain_first;
        bit          hold_trigger;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    dsfs_in_if  req_ch ();
    dsfs_out_if rsp_ch ();

    dual_server_fifo_service_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (req_ch),
        .o_out_ch (rsp_ch)
    );

    // stimulus and idling per phase
    t_request    job_requests[$];
    int unsigned send_idle_pct[3] = '{38, 62, 0};
    int unsigned recv_idle_pct[3] = '{62, 38, 0};
    int unsigned build_phase      = 0;
    bit          next_drain       = 1'b0;
    bit          next_hold        = 1'b0;
    int unsigned cur_phase        = 0;
    logic        hold_off_go      = 1'b0;
    int unsigned hold_left        = 0;
    int unsigned cycle_count      = 0;

    // predicted server queues
    logic [ID_W-1:0]   job_id   [NSRV][QDEPTH];
    logic [TICK_W-1:0] job_left [NSRV][QDEPTH];
    int unsigned       q_head   [NSRV] = '{default: 0};
    int unsigned       q_tail   [NSRV] = '{default: 0};
    int unsigned       q_fill   [NSRV] = '{default: 0};
    t_out_word         reports_due[$];
    logic              drained     = 1'b1;
    int unsigned       fault_count = 0;

    function automatic void add_req(input logic kind, input logic srv,
                                    input logic [ID_W-1:0] id,
                                    input logic [TICK_W-1:0] ticks);
        t_request r;
        r.word.kind          = kind;
        r.word.server        = srv;
        r.word.client_id     = id;
        r.word.service_ticks = ticks;
        r.phase              = build_phase;
        r.drain_first        = next_drain;
        r.hold_trigger       = next_hold;
        next_drain           = 1'b0;
        next_hold            = 1'b0;
        job_requests.push_back(r);
    endfunction

    // apply one accepted word to the predicted queues, queue its reports
    task automatic advance_servers(input t_in_word w);
        int unsigned       s;
        int unsigned       h;
        logic [TICK_W-1:0] t;
        t_out_word         r;
        if (w.kind == KIND_ENQ) begin
            s              = 32'(w.server);
            r.server_index = w.server;
            r.served_id    = w.client_id;
            r.last         = 1'b1;
            if (s >= NSRV || q_fill[s] >= QDEPTH) begin
                r.status = ST_DROP;
            end else begin
                t = (w.service_ticks == '0) ? TICK_W'(1) : w.service_ticks;
                job_id[s][q_tail[s]]   = w.client_id;
                job_left[s][q_tail[s]] = t;
                q_tail[s]              = (q_tail[s] + 1) % QDEPTH;
                q_fill[s]++;
                r.status = ST_ENQ;
            end
            reports_due.push_back(r);
        end else begin
            for (int k = 0; k < NSRV; k++) begin
                r.server_index = k[0];
                r.last         = (k == NSRV - 1);
                if (q_fill[k] == 0) begin
                    r.status    = ST_IDLE;
                    r.served_id = '0;
                end else begin
                    h           = q_head[k];
                    r.status    = ST_PROC;
                    r.served_id = job_id[k][h];
                    if (job_left[k][h] != '0)
                        job_left[k][h] = job_left[k][h] - 1'b1;
                    if (job_left[k][h] == '0) begin
                        q_head[k] = (q_head[k] + 1) % QDEPTH;
                        q_fill[k]--;
                    end
                end
                reports_due.push_back(r);
            end
        end
    endtask

    task automatic report_fault(input string what, input t_out_word want,
                                input t_out_word got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: want srv=%0d st=%0d id=%h last=%0d, %s srv=%0d st=%0d id=%h last=%0d",
                     what, want.server_index, want.status, want.served_id,
                     want.last, "got", got.server_index, got.status,
                     got.served_id, got.last);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_dual_server_fifo_service_core NOT OK");
            $finish;
        end
    end

    // driver: offer the next word once the current one is taken
    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        logic     go;
        logic     kick;
        kick = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            go = 1'b0;
            if (job_requests.size() != 0) begin
                nxt = job_requests[0];
                // hold a phase opener until every report is back
                if (nxt.drain_first && (req_ch.valid || !drained))
                    go = 1'b0;
                else
                    go = ($urandom_range(99) >= send_idle_pct[nxt.phase]);
            end
            if (go) begin
                void'(job_requests.pop_front());
                req_ch.data <= nxt.word;
                cur_phase   <= nxt.phase;
                kick = nxt.hold_trigger;
            end
            req_ch.valid <= go;
        end
        hold_off_go <= kick;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_off_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (hold_left == 0) &&
                            ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end

    // monitor: predict on accepted requests, check accepted reports
    always @(posedge i_clk) begin : watch_reports
        t_out_word got;
        t_out_word want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                advance_servers(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (reports_due.size() == 0) begin
                    report_fault("unexpected word", '0, got);
                end else begin
                    want = reports_due.pop_front();
                    if (got.server_index !== want.server_index ||
                        got.status !== want.status ||
                        got.served_id !== want.served_id ||
                        got.last !== want.last)
                        report_fault("mismatch", want, got);
                end
            end
        end
        drained <= (reports_due.size() == 0);
    end

    initial begin : run_test
        int unsigned base;
        int unsigned pick;
        int unsigned n;
        logic        s;
        bit          hold_done;
        hold_done = 1'b0;
        i_rst_n   = 1'b0;

        // directed: idle servers, zero ticks, id extremes, pops on both servers
        add_req(KIND_TICK, 1'b1, 16'h0000, 16'h0000);
        add_req(KIND_ENQ,  1'b0, 16'h0000, 16'h0000);
        add_req(KIND_ENQ,  1'b1, 16'hFFFF, 16'h0001);
        add_req(KIND_TICK, 1'b0, 16'hFFFF, 16'hFFFF);
        add_req(KIND_TICK, 1'b1, 16'h0000, 16'h0000);
        add_req(KIND_ENQ,  1'b0, 16'h1234, 16'h0003);
        add_req(KIND_ENQ,  1'b0, 16'hABCD, 16'h0002);
        add_req(KIND_ENQ,  1'b1, 16'h8001, 16'h0000);
        add_req(KIND_ENQ,  1'b1, 16'h7FFE, 16'h0002);
        repeat (7) add_req(KIND_TICK, 1'b1, 16'h5A5A, 16'hA5A5);
        add_req(KIND_ENQ,  1'b1, 16'hFFFF, 16'h0001);
        add_req(KIND_TICK, 1'b0, 16'h0000, 16'h0000);
        add_req(KIND_TICK, 1'b0, 16'h0000, 16'h0000);

        for (int ph = 0; ph < 3; ph++) begin
            build_phase = ph;
            if (ph != 0)
                next_drain = 1'b1;
            base = job_requests.size();
            while (job_requests.size() - base < RANDOM_PER_PHASE) begin
                if (ph == 2 && !hold_done && job_requests.size() - base >= 40) begin
                    next_hold = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 55) begin
                    n = $urandom_range(6, 1);
                    repeat (n) add_req(KIND_ENQ, 1'($urandom_range(1)), 16'($urandom),
                                       16'($urandom_range(3)));
                    n = $urandom_range(8, 1);
                    repeat (n) add_req(KIND_TICK, 1'($urandom_range(1)), 16'($urandom),
                                       16'($urandom));
                end else if (pick < 59) begin
                    // overfill one server, then send ticks to work it down
                    s = 1'($urandom_range(1));
                    n = $urandom_range(36, 33);
                    repeat (n) add_req(KIND_ENQ, s, 16'($urandom), 16'($urandom_range(2)));
                    n = $urandom_range(40, 20);
                    repeat (n) add_req(KIND_TICK, 1'($urandom_range(1)), 16'($urandom),
                                       16'($urandom));
                end else if (pick < 80) begin
                    n = $urandom_range(15, 3);
                    repeat (n) add_req(KIND_TICK, 1'($urandom_range(1)), 16'($urandom),
                                       16'($urandom));
                end else begin
                    add_req(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                            16'($urandom_range(7)));
                end
            end
        end

        // long service times only at the end, where they cannot clog later traffic
        repeat (100) add_req(KIND_TICK, 1'($urandom_range(1)), 16'($urandom),
                             16'($urandom));
        add_req(KIND_ENQ, 1'b0, 16'hFFFF, 16'hFFFF);
        add_req(KIND_ENQ, 1'b1, 16'($urandom), 16'h8000 | 16'($urandom));
        repeat (3) add_req(KIND_TICK, 1'($urandom_range(1)), 16'($urandom),
                           16'($urandom));
        add_req(KIND_ENQ, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_requests.size() != 0 || req_ch.valid)
            @(negedge i_clk);
        while (reports_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fault_count == 0 && reports_due.size() == 0)
            $display("tb_dual_server_fifo_service_core OK");
        else
            $display("tb_dual_server_fifo_service_core NOT OK");
        $finish;
    end

endmodule
